### hw/rtl/lkv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lkv_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int RANK_W = IDX_W;
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int CAP_W  = 5;
	localparam int CMP_W  = CNT_W + CAP_W;

	localparam int IN_BITS  = KEY_BITS + VALUE_BITS;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = 1 + VALUE_BITS + 1 + KEY_BITS + CAP_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [RANK_W-1:0]   rank;
	} meta_t;

	typedef struct packed {
		logic                found;
		logic [IDX_W-1:0]    found_idx;
		logic [RANK_W-1:0]   found_rank;
		logic                lru_any;
		logic [IDX_W-1:0]    lru_idx;
		logic [RANK_W-1:0]   lru_rank;
		logic [KEY_BITS-1:0] lru_key;
		logic                free_any;
		logic [IDX_W-1:0]    free_idx;
	} scan_res_t;

endpackage

`default_nettype wire

### hw/rtl/lkv_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lkv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/lkv_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module lkv_scan (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          clear,
	input  wire logic                          en,
	input  wire logic [lkv_pkg::IDX_W-1:0]     idx,
	input  wire logic                          entry_vld,
	input  wire lkv_pkg::meta_t                meta,
	input  wire logic [lkv_pkg::KEY_BITS-1:0]  key,
	output lkv_pkg::scan_res_t                 res
);

	lkv_pkg::scan_res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (clear) begin
			res_q <= '0;
		end else if (en) begin
			// first match wins
			if (entry_vld && meta.key == key && !res_q.found) begin
				res_q.found      <= 1'b1;
				res_q.found_idx  <= idx;
				res_q.found_rank <= meta.rank;
			end
			// oldest valid entry, earliest on a tie
			if (entry_vld && (!res_q.lru_any || meta.rank > res_q.lru_rank)) begin
				res_q.lru_any  <= 1'b1;
				res_q.lru_idx  <= idx;
				res_q.lru_rank <= meta.rank;
				res_q.lru_key  <= meta.key;
			end
			if (!entry_vld && !res_q.free_any) begin
				res_q.free_any <= 1'b1;
				res_q.free_idx <= idx;
			end
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

### hw/rtl/lru_key_value_cache_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Fully associative key/value cache with least-recently-used replacement.
// Request channel (s_axis_*): tuser[0] is the access kind (0 get, 1 set),
// tdata carries key and write value. A request is taken only while the
// core is idle; one result leaves on m_axis_* for every request.
// Keys, values and recency ranks live in two single-port-read memories;
// valid bits and the occupancy count are flip-flops.
// Each request walks the key/rank memory once to find the match, the
// oldest entry and the first free slot, takes a decision step, then
// walks it again to age ranks and ends in an output step; a get that
// misses skips the second walk and goes straight to the output step.
// Capacity is written through cfg_we/cfg_wdata while idle; the user
// must keep to this, the block does not enforce it. 0 acts as 1,
// values above ENTRIES act as ENTRIES.
// Reset empties the cache at once (valid bits clear), capacity returns
// to 16. A stalled receiver holds the result in the output register; the
// next request may be taken meanwhile, and its result waits until the
// output register is free.
module lru_key_value_cache_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	// key, write_value
	input  wire logic [lkv_pkg::IN_W-1:0]    s_axis_tdata,
	// mode
	input  wire logic [0:0]                  s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	// hit, read_value, evicted, evicted_key, occupancy
	output logic      [lkv_pkg::OUT_W-1:0]   m_axis_tdata,
	input  wire logic                        cfg_we,
	input  wire logic [lkv_pkg::CAP_W-1:0]   cfg_wdata
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_DECIDE = 5'b00100,
		S_UPD    = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	localparam int IW = lkv_pkg::IDX_W;
	localparam int RW = lkv_pkg::RANK_W;
	localparam int CW = lkv_pkg::CNT_W;
	localparam int KB = lkv_pkg::KEY_BITS;
	localparam int VB = lkv_pkg::VALUE_BITS;
	localparam int MW = $bits(lkv_pkg::meta_t);

	state_t                   state_q;
	logic [CW-1:0]            cnt_q;
	logic                     rd_vld_s1;
	logic [IW-1:0]            rd_idx_s1;
	logic                     mode_q;
	logic [KB-1:0]            key_q;
	logic [VB-1:0]            wval_q;
	logic [lkv_pkg::ENTRIES-1:0] valid_q;
	logic [CW-1:0]            count_q;
	logic [lkv_pkg::CAP_W-1:0] cap_q;
	logic [IW-1:0]            slot_q;
	logic [RW:0]              thr_q;
	logic                     hit_q;
	logic                     ev_q;
	logic [KB-1:0]            evkey_q;
	logic [VB-1:0]            rval_q;
	logic                     vrd_s1;
	logic                     out_valid_q;
	logic [lkv_pkg::OUT_W-1:0] out_data_q;

	logic                     in_acc;
	logic                     walking;
	logic                     issue;
	logic                     walk_end;
	lkv_pkg::meta_t           meta_rd;
	lkv_pkg::meta_t           meta_wr;
	logic                     meta_we;
	logic                     rank_inc;
	lkv_pkg::scan_res_t       res;
	logic                     at_cap;
	logic                     dec_evict;
	logic [IW-1:0]            dec_slot;
	logic                     vram_we;
	logic [IW-1:0]            vram_waddr;
	logic                     vram_re;
	logic [VB-1:0]            vram_rdata;
	logic                     out_load;
	logic [lkv_pkg::CMP_W-1:0] cap_x;
	logic [lkv_pkg::CMP_W-1:0] cnt_x;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign walking       = (state_q == S_SCAN) || (state_q == S_UPD);
	assign issue         = walking && (cnt_q < CW'(lkv_pkg::ENTRIES));
	assign walk_end      = (cnt_q == CW'(lkv_pkg::ENTRIES));
	assign out_load      = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

	// capacity clamp: zero acts as one, anything above the depth as the depth
	assign cap_x = lkv_pkg::CMP_W'(cap_q);
	assign cnt_x = lkv_pkg::CMP_W'(count_q);
	always_comb begin
		if (cap_q == '0) begin
			at_cap = (count_q != '0);
		end else if (cap_x > lkv_pkg::CMP_W'(lkv_pkg::ENTRIES)) begin
			at_cap = (count_q == CW'(lkv_pkg::ENTRIES));
		end else begin
			at_cap = (cnt_x >= cap_x);
		end
	end

	assign dec_evict = at_cap && res.lru_any;
	assign dec_slot  = res.found ? res.found_idx :
	                   (dec_evict ? res.lru_idx : res.free_idx);

	lkv_ram #(
		.WIDTH(MW),
		.DEPTH(lkv_pkg::ENTRIES)
	) u_meta_ram (
		.clk  (clk),
		.we   (meta_we),
		.waddr(rd_idx_s1),
		.wdata(meta_wr),
		.re   (issue),
		.raddr(cnt_q[IW-1:0]),
		.rdata(meta_rd)
	);

	assign vram_we    = (state_q == S_DECIDE) && mode_q;
	assign vram_waddr = dec_slot;
	assign vram_re    = (state_q == S_DECIDE) && res.found && !mode_q;

	lkv_ram #(
		.WIDTH(VB),
		.DEPTH(lkv_pkg::ENTRIES)
	) u_value_ram (
		.clk  (clk),
		.we   (vram_we),
		.waddr(vram_waddr),
		.wdata(wval_q),
		.re   (vram_re),
		.raddr(res.found_idx),
		.rdata(vram_rdata)
	);

	lkv_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (in_acc),
		.en       ((state_q == S_SCAN) && rd_vld_s1),
		.idx      (rd_idx_s1),
		.entry_vld(valid_q[rd_idx_s1]),
		.meta     (meta_rd),
		.key      (key_q),
		.res      (res)
	);

	// age every valid entry newer than the threshold; the touched slot goes to zero
	assign rank_inc = ({1'b0, meta_rd.rank} < thr_q);
	always_comb begin
		meta_wr = meta_rd;
		if (rd_idx_s1 == slot_q) begin
			meta_wr.key  = key_q;
			meta_wr.rank = '0;
		end else if (rank_inc) begin
			meta_wr.rank = meta_rd.rank + RW'(1);
		end
	end
	assign meta_we = (state_q == S_UPD) && rd_vld_s1 &&
	                 (valid_q[rd_idx_s1] || rd_idx_s1 == slot_q);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q <= s_axis_tuser[0];
			key_q  <= s_axis_tdata[KB-1:0];
			wval_q <= s_axis_tdata[KB+VB-1:KB];
		end
		rd_idx_s1 <= cnt_q[IW-1:0];
		if (state_q == S_DECIDE) begin
			slot_q  <= dec_slot;
			thr_q   <= res.found ? {1'b0, res.found_rank} : (RW+1)'(lkv_pkg::ENTRIES);
			hit_q   <= res.found;
			ev_q    <= !res.found && mode_q && dec_evict;
			evkey_q <= (!res.found && mode_q && dec_evict) ? res.lru_key : '0;
			rval_q  <= '0;
		end
		if (vrd_s1) begin
			rval_q <= vram_rdata;
		end
		if (out_load) begin
			out_data_q <= lkv_pkg::OUT_W'({lkv_pkg::CAP_W'(count_q), evkey_q, ev_q,
			                               rval_q, hit_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			vrd_s1      <= 1'b0;
			valid_q     <= '0;
			count_q     <= '0;
			cap_q       <= lkv_pkg::CAP_W'(16);
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			vrd_s1    <= vram_re;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (in_acc) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (walk_end) begin
						cnt_q   <= '0;
						state_q <= S_DECIDE;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_DECIDE: begin
					cnt_q <= '0;
					if (res.found) begin
						state_q <= S_UPD;
					end else if (mode_q) begin
						// insert; an eviction reuses the same slot
						valid_q[dec_slot] <= 1'b1;
						if (!dec_evict) begin
							count_q <= count_q + CW'(1);
						end
						state_q <= S_UPD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_UPD: begin
					if (walk_end) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q))
		else $error("occupancy count differs from valid bits");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(lkv_pkg::ENTRIES))
		else $error("occupancy above depth");

	a_evict_has_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE) && mode_q && !res.found && at_cap |-> res.lru_any)
		else $error("full cache without an oldest entry");

	a_insert_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE) && mode_q && !res.found && !at_cap |-> res.free_any)
		else $error("insert without a free slot");

	a_evict_not_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) && ev_q |-> !hit_q)
		else $error("eviction flagged on a hit");

endmodule

`default_nettype wire

### sim/cache_monitor.sv
`timescale 1ns / 1ps
`default_nettype none

module cache_monitor (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	input  wire logic                        s_axis_tready,
	// key, write_value
	input  wire logic [lkv_pkg::IN_W-1:0]    s_axis_tdata,
	// mode
	input  wire logic [0:0]                  s_axis_tuser,
	input  wire logic                        m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	// hit, read_value, evicted, evicted_key, occupancy
	input  wire logic [lkv_pkg::OUT_W-1:0]   m_axis_tdata,
	input  wire logic                        cfg_we,
	input  wire logic [lkv_pkg::CAP_W-1:0]   cfg_wdata,
	output int                               mismatches,
	output int                               outstanding
);
	import lkv_pkg::*;

	typedef struct packed {
		logic                  hit;
		logic [VALUE_BITS-1:0] read_value;
		logic                  evicted;
		logic [KEY_BITS-1:0]   evicted_key;
		logic [CAP_W-1:0]      occupancy;
	} access_result_t;

	logic                  slot_valid [ENTRIES];
	logic [KEY_BITS-1:0]   slot_key   [ENTRIES];
	logic [VALUE_BITS-1:0] slot_value [ENTRIES];
	logic [RANK_W-1:0]     slot_age   [ENTRIES];
	logic [CNT_W-1:0]      live_count;
	logic [CAP_W-1:0]      capacity_reg;

	access_result_t pending_results [$];
	access_result_t want, got;
	int             fault_total = 0;

	function automatic access_result_t cache_access(input logic is_set,
			input logic [KEY_BITS-1:0] key, input logic [VALUE_BITS-1:0] wval);
		access_result_t    r;
		int                i, match, victim, limit;
		logic [RANK_W-1:0] age;
		r = '0;
		match = -1;
		victim = -1;
		for (i = 0; i < ENTRIES; i++)
			if (match < 0 && slot_valid[i] && slot_key[i] == key)
				match = i;
		if (match >= 0) begin
			r.hit = 1'b1;
			if (is_set)
				slot_value[match] = wval;
			else
				r.read_value = slot_value[match];
			// age only the entries that were more recent than the one touched
			age = slot_age[match];
			for (i = 0; i < ENTRIES; i++)
				if (slot_valid[i] && i != match && slot_age[i] < age)
					slot_age[i] = slot_age[i] + 1'b1;
			slot_age[match] = '0;
		end else if (is_set) begin
			limit = (capacity_reg == 0) ? 1 :
				(capacity_reg > ENTRIES) ? ENTRIES : int'(capacity_reg);
			if (live_count >= limit) begin
				// oldest entry, lowest index on a tie
				for (i = 0; i < ENTRIES; i++)
					if (slot_valid[i] && (victim < 0 || slot_age[i] > slot_age[victim]))
						victim = i;
				if (victim >= 0) begin
					r.evicted = 1'b1;
					r.evicted_key = slot_key[victim];
					slot_valid[victim] = 1'b0;
					live_count = live_count - 1'b1;
				end
			end
			if (victim < 0)
				for (i = ENTRIES - 1; i >= 0; i--)
					if (!slot_valid[i])
						victim = i;
			if (victim >= 0) begin
				for (i = 0; i < ENTRIES; i++)
					if (slot_valid[i])
						slot_age[i] = slot_age[i] + 1'b1;
				slot_valid[victim] = 1'b1;
				slot_key[victim] = key;
				slot_value[victim] = wval;
				slot_age[victim] = '0;
				live_count = live_count + 1'b1;
			end
		end
		r.occupancy = CAP_W'(live_count);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				slot_valid[i] = 1'b0;
				slot_key[i] = '0;
				slot_value[i] = '0;
				slot_age[i] = '0;
			end
			live_count = '0;
			capacity_reg = CAP_W'(ENTRIES);
			pending_results.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.hit         = m_axis_tdata[0];
				got.read_value  = m_axis_tdata[1 +: VALUE_BITS];
				got.evicted     = m_axis_tdata[VALUE_BITS + 1];
				got.evicted_key = m_axis_tdata[VALUE_BITS + 2 +: KEY_BITS];
				got.occupancy   = m_axis_tdata[VALUE_BITS + KEY_BITS + 2 +: CAP_W];
				if (pending_results.size() == 0) begin
					$error("result with no request waiting: %h", m_axis_tdata);
					fault_total++;
				end else begin
					want = pending_results.pop_front();
					if (got.hit !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, got.hit);
						fault_total++;
					end
					if (got.read_value !== want.read_value) begin
						$error("read_value: expected %h, got %h",
							want.read_value, got.read_value);
						fault_total++;
					end
					if (got.evicted !== want.evicted) begin
						$error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
						fault_total++;
					end
					if (got.evicted_key !== want.evicted_key) begin
						$error("evicted_key: expected %h, got %h",
							want.evicted_key, got.evicted_key);
						fault_total++;
					end
					if (got.occupancy !== want.occupancy) begin
						$error("occupancy: expected %0d, got %0d",
							want.occupancy, got.occupancy);
						fault_total++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				pending_results.push_back(cache_access(s_axis_tuser[0],
					s_axis_tdata[0 +: KEY_BITS], s_axis_tdata[KEY_BITS +: VALUE_BITS]));
			if (cfg_we)
				capacity_reg = cfg_wdata;
		end
		mismatches <= fault_total;
		outstanding <= pending_results.size();
	end

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
`default_nettype none

module testbench;
	import lkv_pkg::*;

	localparam int   CYCLE_LIMIT = 400000;
	localparam int   PHASES      = 10;
	localparam int   PHASE_ITEMS = 73;
	localparam int   POOL_SIZE   = 24;
	localparam logic MODE_GET    = 1'b0;
	localparam logic MODE_SET    = 1'b1;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_W-1:0]       s_axis_tdata;
	logic [0:0]            s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_W-1:0]      m_axis_tdata;
	logic                  cfg_we;
	logic [CAP_W-1:0]      cfg_wdata;
	logic                  quiet;
	int                    mismatches;
	int                    outstanding;
	int                    cycle_count = 0;
	int                    gap_odds = 4;
	logic [KEY_BITS-1:0]   key_pool [POOL_SIZE];
	logic [CAP_W-1:0]      capacity_plan [PHASES];

	lru_key_value_cache_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	cache_monitor monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// result side: random stall bursts, always ready once quiet
	initial begin
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (quiet || $urandom_range(0, 2) != 0) begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end
	end

	task automatic send_request(input logic mode, input logic [KEY_BITS-1:0] key,
			input logic [VALUE_BITS-1:0] wval);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= IN_W'({wval, key});
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// drop valid and hold until every request has its result back
	task automatic finish_phase();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic random_requests(input int count, input int span);
		logic [KEY_BITS-1:0] k;
		repeat (count) begin
			if ($urandom_range(0, 9) == 0)
				k = $urandom();
			else
				k = key_pool[$urandom_range(0, span - 1)];
			send_request($urandom_range(0, 1) ? MODE_SET : MODE_GET, k, $urandom());
		end
	endtask

	initial begin
		int phase, span;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= '0;
		quiet         <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty cache, extreme keys and values, update, fill and evict
		send_request(MODE_GET, 32'h0000_0000, 32'hFFFF_FFFF);
		send_request(MODE_SET, 32'h0000_0000, 32'hFFFF_FFFF);
		send_request(MODE_SET, 32'hFFFF_FFFF, 32'h0000_0000);
		send_request(MODE_GET, 32'h0000_0000, 32'h0000_0000);
		send_request(MODE_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(MODE_SET, 32'h0000_0000, 32'h1234_5678);
		send_request(MODE_GET, 32'h0000_0005, 32'h0000_0000);
		for (int i = 0; i < ENTRIES - 2; i++)
			send_request(MODE_SET, KEY_BITS'(100 + i), $urandom());
		send_request(MODE_SET, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
		send_request(MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		send_request(MODE_GET, 32'h0000_0000, 32'h0000_0000);
		finish_phase();

		capacity_plan = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd16, 5'd5, 5'd8, 5'd12, 5'd0};
		capacity_plan[PHASES - 1] = CAP_W'($urandom_range(0, 31));
		foreach (key_pool[i]) key_pool[i] = $urandom();

		for (phase = 0; phase < PHASES; phase++) begin
			cfg_we    <= 1'b1;
			cfg_wdata <= capacity_plan[phase];
			@(posedge clk);
			cfg_we <= 1'b0;
			span = (capacity_plan[phase] == 0) ? 1 :
				(capacity_plan[phase] > ENTRIES) ? ENTRIES : int'(capacity_plan[phase]);
			span = span + $urandom_range(1, 4);
			if (span > POOL_SIZE)
				span = POOL_SIZE;
			// keep part of the pool so resident keys still hit after a capacity change
			foreach (key_pool[i])
				if ($urandom_range(0, 2) == 0)
					key_pool[i] = $urandom();
			if (phase == PHASES - 1) begin
				quiet <= 1'b1;
				gap_odds = 0;
			end else begin
				gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
			end
			random_requests(PHASE_ITEMS, span);
			finish_phase();
		end

		repeat (2 * ENTRIES + 8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
hw/rtl/lkv_pkg.sv
hw/rtl/lkv_ram.sv
hw/rtl/lkv_scan.sv
hw/rtl/lru_key_value_cache_core.sv
sim/cache_monitor.sv
sim/testbench.sv
